// File: rtl/pfcr_pkg.sv
// Package for the page fault counter with readahead.
// Widths, limits, register indexes, the state type and the map port struct.
// No dependencies.
package pfcr_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CUR_W      = PAGE_W + 1;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 24;
    localparam int SUM_W      = ADDR_W + 2;
    localparam int FIRST_W    = 23;
    localparam int STOP_W     = 25;
    localparam int NEWF_W     = 13;
    localparam int TOTAL_W    = 32;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] SHIFT_MIN   = 5'd9;
    localparam logic [CFG_W-1:0] SHIFT_MAX   = 5'd16;
    localparam logic [CFG_W-1:0] SHIFT_RESET = 5'd12;
    localparam logic [CFG_W-1:0] RA_MIN      = 5'd1;
    localparam logic [CFG_W-1:0] RA_MAX      = 5'd16;
    localparam logic [CFG_W-1:0] RA_RESET    = 5'd1;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READAHEAD  = 1'd1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_FIRST = 8'b0000_0100,
        S_STOP  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_MARK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [PAGE_W-1:0] raddr;
    } t_map_req;

endpackage

// File: rtl/pfcr_in_if.sv
// Input channel: one code-block access per transaction.
// Depends on pfcr_pkg.
interface pfcr_in_if;
    import pfcr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] block_size;

    modport source (output valid, output block_address, output block_size, input ready);
    modport sink   (input valid, input block_address, input block_size, output ready);
endinterface

// File: rtl/pfcr_out_if.sv
// Output channel: fault counts for one access per transaction.
// Depends on pfcr_pkg.
interface pfcr_out_if;
    import pfcr_pkg::*;

    logic               valid;
    logic               ready;
    logic [NEWF_W-1:0]  new_faults;
    logic [TOTAL_W-1:0] total_faults;
    logic               out_of_range;

    modport source (output valid, output new_faults, output total_faults,
                    output out_of_range, input ready);
    modport sink   (input valid, input new_faults, input total_faults,
                    input out_of_range, output ready);
endinterface

// File: rtl/pfcr_resident_map.sv
// Residency bitmap: NUM_PAGES x 1 bit, one write and one registered read per cycle.
// Depends on pfcr_pkg.
module pfcr_resident_map (
    input  logic               i_clk,
    input  pfcr_pkg::t_map_req i_req,
    output logic               o_rdata
);
    import pfcr_pkg::*;

    logic r_mem [NUM_PAGES];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/page_fault_counter_readahead.sv
// Top level of the page fault counter with readahead.
// Depends on pfcr_pkg, pfcr_in_if, pfcr_out_if and pfcr_resident_map.
//
// After reset the block clears its residency bitmap, one page a cycle; no
// access is taken meanwhile, configuration writes are. One access is handled
// at a time: S_FIRST and S_STOP find the covered page range through a shared
// barrel shifter, then each page visited is read from the bitmap (S_READ) and
// checked (S_CHECK); a fault marks the readahead pages from the faulting page,
// one page per cycle, after which the walk resumes past the marked pages.
// S_DONE loads the result register once the output register is free. A new
// access is taken while the previous result still waits in the output register.
module page_fault_counter_readahead (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfcr_pkg::CFG_W-1:0]     i_cfg_data,
    pfcr_in_if.sink                        i_in,
    pfcr_out_if.source                     o_out
);
    import pfcr_pkg::*;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_page_shift, r_readahead;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [FIRST_W-1:0] r_first, n_first;
    logic [CUR_W-1:0]   r_limit, n_limit;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [CFG_W-1:0]   r_mark_cnt, n_mark_cnt;
    logic [NEWF_W-1:0]  r_new, n_new;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_oor, n_oor;
    logic               r_out_valid;
    logic [NEWF_W-1:0]  r_out_new;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_oor;

    logic [CFG_W-1:0]   sh, ra;
    logic [SUM_W-1:0]   shift_in, shift_out;
    logic [STOP_W-1:0]  stop;
    logic [CUR_W-1:0]   cur_inc;
    logic               more;
    logic               rd_data;
    logic               out_load;
    t_map_req           map_req;

    pfcr_resident_map u_map (
        .i_clk  (i_clk),
        .i_req  (map_req),
        .o_rdata(rd_data)
    );

    assign sh = (r_page_shift < SHIFT_MIN) ? SHIFT_MIN :
                (r_page_shift > SHIFT_MAX) ? SHIFT_MAX : r_page_shift;
    assign ra = (r_readahead < RA_MIN) ? RA_MIN :
                (r_readahead > RA_MAX) ? RA_MAX : r_readahead;

    // shared shifter: start address first, then end sum
    assign shift_in  = (r_state == S_FIRST) ? SUM_W'(r_addr) : r_sum;
    assign shift_out = shift_in >> sh;
    assign stop      = shift_out[STOP_W-1:0];

    assign cur_inc = r_cur + CUR_W'(1);
    assign more    = cur_inc < r_limit;

    assign i_in.ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_size     = r_size;
        n_sum      = r_sum;
        n_first    = r_first;
        n_limit    = r_limit;
        n_cur      = r_cur;
        n_mark_cnt = r_mark_cnt;
        n_new      = r_new;
        n_total    = r_total;
        n_oor      = r_oor;
        map_req    = '0;
        map_req.raddr = r_cur[PAGE_W-1:0];
        map_req.waddr = r_cur[PAGE_W-1:0];

        case (r_state)
            S_CLEAR: begin
                map_req.we    = 1'b1;
                map_req.wdata = 1'b0;
                n_cur = cur_inc;
                if (r_cur == CUR_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_addr  = i_in.block_address;
                    n_size  = i_in.block_size;
                    n_new   = '0;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                n_first = shift_out[FIRST_W-1:0];
                n_sum   = SUM_W'(r_addr) + SUM_W'(r_size)
                        + ((SUM_W'(1) << sh) - SUM_W'(1));
                n_state = S_STOP;
            end
            S_STOP: begin
                n_oor   = (stop > STOP_W'(r_first)) && (stop > STOP_W'(NUM_PAGES));
                n_limit = (stop > STOP_W'(NUM_PAGES)) ? CUR_W'(NUM_PAGES) : stop[CUR_W-1:0];
                n_cur   = r_first[CUR_W-1:0];
                if (r_first < FIRST_W'(n_limit)) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                map_req.re = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (rd_data) begin
                    n_cur   = cur_inc;
                    n_state = more ? S_READ : S_DONE;
                end else begin
                    if (r_new != '1) begin
                        n_new = r_new + NEWF_W'(1);
                    end
                    if (r_total != '1) begin
                        n_total = r_total + TOTAL_W'(1);
                    end
                    n_mark_cnt = ra;
                    n_state    = S_MARK;
                end
            end
            S_MARK: begin
                map_req.we    = (r_cur < CUR_W'(NUM_PAGES));
                map_req.wdata = 1'b1;
                n_cur      = cur_inc;
                n_mark_cnt = r_mark_cnt - CFG_W'(1);
                if (r_mark_cnt == CFG_W'(1)) begin
                    n_state = more ? S_READ : S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cur   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cur        <= '0;
            r_total      <= '0;
            r_page_shift <= SHIFT_RESET;
            r_readahead  <= RA_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_total <= n_total;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PAGE_SHIFT: r_page_shift <= i_cfg_data;
                    REG_READAHEAD:  r_readahead  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_size     <= n_size;
        r_sum      <= n_sum;
        r_first    <= n_first;
        r_limit    <= n_limit;
        r_mark_cnt <= n_mark_cnt;
        r_new      <= n_new;
        r_oor      <= n_oor;
        if (out_load) begin
            r_out_new   <= r_new;
            r_out_total <= r_total;
            r_out_oor   <= r_oor;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.new_faults   = r_out_new;
    assign o_out.total_faults = r_out_total;
    assign o_out.out_of_range = r_out_oor;

endmodule

// File: test/tb_page_fault_counter_readahead.sv
// Self-checking testbench for page_fault_counter_readahead.
// Directed table then random accesses under four idle/stall phases, scored against
// an in-bench residency model. Depends on pfcr_pkg, pfcr_in_if, pfcr_out_if and the RTL.
module tb_page_fault_counter_readahead;
    timeunit 1ns;
    timeprecision 1ps;
    import pfcr_pkg::*;

    typedef struct packed {
        logic [NEWF_W-1:0]  new_faults;
        logic [TOTAL_W-1:0] total;
        logic               oor;
    } t_fault_result;

    typedef enum bit {ROW_ACCESS, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [CFG_W-1:0]  pg_shift;
        logic [CFG_W-1:0]  ra;
        bit                typed;
        t_fault_result     want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    pfcr_in_if  in_if();
    pfcr_out_if out_if();

    page_fault_counter_readahead DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // model state
    bit                 page_loaded [NUM_PAGES];
    logic [TOTAL_W-1:0] faults_so_far;
    logic [CFG_W-1:0]   shift_reg;
    logic [CFG_W-1:0]   ra_reg;

    t_fault_result pending_counts[$];
    t_dir_row      dir_tab[$];
    t_fault_result got_res;
    t_fault_result want_res;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int          err_count;
    int          accesses_sent;
    int          results_checked;
    int          faults_seen;
    int          oor_seen;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_cfg(input logic [CFG_W-1:0] v,
                                              input logic [CFG_W-1:0] lo,
                                              input logic [CFG_W-1:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Walks the covered pages and updates residency and the running total.
    function automatic t_fault_result count_faults(input logic [ADDR_W-1:0] addr,
                                                   input logic [SIZE_W-1:0] size);
        t_fault_result   r;
        int unsigned     sh;
        int unsigned     ra;
        longint unsigned first_pg;
        longint unsigned stop_pg;
        longint unsigned last_pg;
        r = '0;
        sh = clamp_cfg(shift_reg, SHIFT_MIN, SHIFT_MAX);
        ra = clamp_cfg(ra_reg, RA_MIN, RA_MAX);
        first_pg = 64'(addr) >> sh;
        stop_pg = (64'(addr) + 64'(size) + (64'd1 << sh) - 64'd1) >> sh;
        last_pg = (stop_pg < NUM_PAGES) ? stop_pg : NUM_PAGES;
        r.oor = (stop_pg > first_pg) && (stop_pg > NUM_PAGES);
        for (longint unsigned p = first_pg; p < last_pg; p++) begin
            if (!page_loaded[p]) begin
                if (r.new_faults != '1) r.new_faults++;
                if (faults_so_far != '1) faults_so_far++;
                for (int unsigned j = 0; j < ra; j++) begin
                    if (p + j < NUM_PAGES) page_loaded[p + j] = 1'b1;
                end
            end
        end
        r.total = faults_so_far;
        return r;
    endfunction

    function automatic void tab_access(input logic [ADDR_W-1:0] addr,
                                       input logic [SIZE_W-1:0] size, input bit typed,
                                       input int nf, input int tot, input bit oor);
        t_dir_row row;
        row = '{ROW_ACCESS, addr, size, '0, '0, typed, '0};
        row.want.new_faults = NEWF_W'(nf);
        row.want.total = TOTAL_W'(tot);
        row.want.oor = oor;
        dir_tab.push_back(row);
    endfunction

    function automatic void tab_config(input logic [CFG_W-1:0] pg_shift,
                                       input logic [CFG_W-1:0] ra);
        t_dir_row row;
        row = '{ROW_CONFIG, '0, '0, pg_shift, ra, 1'b0, '0};
        dir_tab.push_back(row);
    endfunction

    function automatic void pick_access(output logic [ADDR_W-1:0] addr,
                                        output logic [SIZE_W-1:0] size);
        int unsigned       sh;
        int unsigned       sel;
        logic [ADDR_W-1:0] low_mask;
        sh = clamp_cfg(shift_reg, SHIFT_MIN, SHIFT_MAX);
        low_mask = (32'd1 << sh) - 32'd1;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            addr = ($urandom_range(0, NUM_PAGES - 1) << sh) | ($urandom & low_mask);
            size = SIZE_W'($urandom_range(0, 3 << sh));
        end else if (sel < 80) begin
            addr = ($urandom_range(NUM_PAGES - 6, NUM_PAGES - 1) << sh) | ($urandom & low_mask);
            size = SIZE_W'($urandom_range(0, 16 << sh));
        end else if (sel < 90) begin
            addr = $urandom_range(0, NUM_PAGES + 3) << sh;
            if ($urandom_range(0, 1)) addr = addr | ($urandom & low_mask);
            size = '0;
        end else if (sel < 97) begin
            addr = $urandom;
            size = SIZE_W'($urandom_range(0, 4095));
        end else begin
            addr = $urandom;
            size = SIZE_W'($urandom);
        end
    endfunction

    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size,
                               input bit typed, input t_fault_result want);
        t_fault_result r;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_if.valid         <= 1'b1;
        in_if.block_address <= addr;
        in_if.block_size    <= size;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        r = count_faults(addr, size);
        pending_counts.push_back(typed ? want : r);
        accesses_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] pg_shift, input logic [CFG_W-1:0] ra);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PAGE_SHIFT;
        i_cfg_data  <= pg_shift;
        @(posedge i_clk);
        i_cfg_index <= REG_READAHEAD;
        i_cfg_data  <= ra;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        shift_reg = pg_shift;
        ra_reg    = ra;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got_res = '{out_if.new_faults, out_if.total_faults, out_if.out_of_range};
            if (pending_counts.size() == 0) begin
                err_count++;
                $display("%0t: unexpected transaction, got new %0d total %0d oor %0b",
                         $time, got_res.new_faults, got_res.total, got_res.oor);
            end else begin
                want_res = pending_counts.pop_front();
                results_checked++;
                faults_seen += got_res.new_faults;
                if (got_res.oor) oor_seen++;
                if (got_res.new_faults !== want_res.new_faults) begin
                    err_count++;
                    $display("%0t: new_faults expected %0d, got %0d",
                             $time, want_res.new_faults, got_res.new_faults);
                end
                if (got_res.total !== want_res.total) begin
                    err_count++;
                    $display("%0t: total_faults expected %0d, got %0d",
                             $time, want_res.total, got_res.total);
                end
                if (got_res.oor !== want_res.oor) begin
                    err_count++;
                    $display("%0t: out_of_range expected %0b, got %0b",
                             $time, want_res.oor, got_res.oor);
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("tb_page_fault_counter_readahead: done, errors");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_PAGE_SHIFT;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.block_address = '0;
        in_if.block_size = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        err_count = 0;
        accesses_sent = 0;
        results_checked = 0;
        faults_seen = 0;
        oor_seen = 0;
        faults_so_far = '0;
        shift_reg = SHIFT_RESET;
        ra_reg = RA_RESET;
        foreach (page_loaded[p]) page_loaded[p] = 1'b0;

        // reset values: 4 KiB pages, readahead 1
        tab_access(32'h0000_0000, 24'h000000, 1, 0, 0, 0);  // aligned, zero size
        tab_access(32'h0000_0001, 24'h000000, 1, 1, 1, 0);  // unaligned, zero size
        tab_access(32'h0000_0000, 24'h001000, 1, 0, 1, 0);
        tab_access(32'hFFFF_FFFF, 24'hFFFFFF, 1, 0, 1, 1);
        tab_access(32'h00FF_F000, 24'h002000, 1, 1, 2, 1);  // straddles end of map
        tab_access(32'h00FF_FFFF, 24'h000001, 1, 0, 2, 0);
        tab_access(32'h0100_0000, 24'h000000, 1, 0, 2, 0);
        tab_access(32'h0100_0001, 24'h000000, 1, 0, 2, 1);
        tab_access(32'h0000_5000, 24'h003000, 0, 0, 0, 0);
        tab_config(5'd0, 5'd0);
        tab_access(32'h0000_0A00, 24'h000400, 0, 0, 0, 0);
        tab_access(32'h001F_FE00, 24'h000200, 0, 0, 0, 0);
        tab_config(5'd31, 5'd31);
        tab_access(32'h0FFF_0000, 24'hFFFFFF, 0, 0, 0, 0);
        tab_access(32'h0010_0000, 24'h010000, 0, 0, 0, 0);
        tab_access(32'h0020_0001, 24'h000000, 0, 0, 0, 0);
        tab_access(32'h0011_0000, 24'h030000, 0, 0, 0, 0);
        tab_config(5'd9, 5'd16);
        tab_access(32'h0001_0000, 24'h001000, 0, 0, 0, 0);
        tab_access(32'h001F_FC00, 24'h000400, 0, 0, 0, 0);  // readahead past end
        tab_access(32'hFFFF_FE00, 24'h0001FF, 0, 0, 0, 0);
        tab_config(5'd16, 5'd1);
        tab_access(32'hFFFF_0000, 24'h00FFFF, 0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CONFIG) begin
                drain_results();
                set_config(dir_tab[k].pg_shift, dir_tab[k].ra);
            end else begin
                send_access(dir_tab[k].addr, dir_tab[k].size, dir_tab[k].typed,
                            dir_tab[k].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    send_idle_pct = 0;  stall_pct = 0;  set_config(5'd12, 5'd1);
                end
                1: begin
                    send_idle_pct = 45; stall_pct = 0;  set_config(5'd9, 5'd2);
                end
                2: begin
                    send_idle_pct = 0;  stall_pct = 45; set_config(5'd16, 5'd4);
                end
                default: begin
                    send_idle_pct = 11; stall_pct = 11; set_config(5'd13, 5'd16);
                end
            endcase
            for (int n = 0; n < 257; n++) begin
                pick_access(addr, size);
                send_access(addr, size, 1'b0, '0);
                if ($urandom_range(0, 39) == 0) drain_results();
            end
        end

        // sweep the whole map with the smallest pages
        drain_results();
        send_idle_pct = 0;
        stall_pct = 0;
        set_config(5'd9, 5'd1);
        send_access(32'h0000_0000, 24'hFFFFFF, 1'b0, '0);
        send_access(32'h0000_0000, 24'hFFFFFF, 1'b0, '0);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, pending_counts.size());
        end
        $display("Sent %0d accesses over four idle/stall phases,", accesses_sent);
        $display("page shifts 9..16, readahead 1..16.");
        $display("Checked %0d results: %0d faults, %0d out of range, %0d mismatches.",
                 results_checked, faults_seen, oor_seen, err_count);
        if (err_count == 0) begin
            $display("tb_page_fault_counter_readahead: done, clean");
        end else begin
            $display("tb_page_fault_counter_readahead: done, errors");
        end
        $finish;
    end

endmodule
